/* sv/palt_pkg.sv */
// shared types and constants for the padded adjacency list table
// command and result words, operation codes, register indexes, defaults
// no dependencies
package palt_pkg;

	localparam int NODES_DEF      = 64;
	localparam int MAX_DEGREE_DEF = 16;

	localparam logic [7:0] EMPTY_SLOT = 8'd255;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_ADD   = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_LOAD  = 2'd3;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_CAPACITY = 2'd1;

	localparam logic [6:0] NODE_COUNT_RST   = 7'd64;
	localparam logic [4:0] ROW_CAPACITY_RST = 5'd16;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  node;
		logic [5:0]  neighbor;
		logic [3:0]  slot;
		logic [63:0] row_bits;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       overflow;
		logic [4:0] row_fill;
		logic [6:0] max_degree_seen;
	} res_word_t;

	typedef struct packed {
		logic        found;
		logic [5:0]  idx;
		logic [63:0] rest;
	} lowbit_t;

endpackage

/* sv/palt_lowbit.sv */
// lowest set bit finder for the matrix row scan
// returns the index of the lowest set bit and the row with that bit removed
// depends on palt_pkg
module palt_lowbit
	import palt_pkg::*;
(
	input  logic [63:0] bits,
	output lowbit_t     pick
);

	always_comb begin
		pick.idx = 6'd0;
		for (int i = 63; i >= 0; i--) begin
			if (bits[i]) begin
				pick.idx = 6'(i);
			end
		end
		pick.found = |bits;
		pick.rest  = bits & (bits - 64'd1);
	end

endmodule

/* sv/padded_adjacency_list_table.sv */
// Fixed-stride neighbor table. A command is taken when start is high and busy is low;
// its result appears for one cycle with done and must be taken then. clear stays idle
// (done on the next cycle, a new command may follow at once); add_edge and read_slot
// go through the read and write-back states; load_row also scans the set bits below
// node_count one per cycle, bounded by the single write port of the neighbor memory,
// which stores one neighbor per cycle. Row lengths live in a second memory with a
// valid bit per row, so clear and reset need no sweep of the neighbor memory.
// depends on palt_pkg and palt_lowbit
module padded_adjacency_list_table
	import palt_pkg::*;
#(
	parameter int NODES      = NODES_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_word_t            cmd,
	output logic                 done,
	output res_word_t            result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int DEPTH = NODES * MAX_DEGREE;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(NODES);
	localparam logic [7:0]    NODES8 = 8'(NODES);
	localparam logic [6:0]    MD7    = 7'(MAX_DEGREE);
	localparam logic [AW-1:0] STRIDE = AW'(MAX_DEGREE);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_WB   = 2'd3;

	logic [1:0] state_q;

	logic [6:0] node_count_q;
	logic [4:0] row_cap_q;
	logic [4:0] cap;

	logic [7:0]    tbl_mem [DEPTH];
	logic [4:0]    len_mem [NODES];
	logic [NODES-1:0] vld_q;

	logic [7:0]    tbl_rd_q;
	logic [4:0]    len_rd_q;
	logic          vld_rd_q;

	logic [1:0]    kind_q;
	logic [5:0]    neighbor_q;
	logic [3:0]    slot_q;
	logic          node_ok_q;
	logic          slot_ok_q;
	logic [NW-1:0] node_idx_q;
	logic [AW-1:0] base_q;
	logic [63:0]   bits_q;
	logic [4:0]    len_q;
	logic [6:0]    deg_q;
	logic          ovf_q;
	logic [7:0]    rv_q;
	logic [6:0]    max_q;

	logic          done_q;
	res_word_t     res_q;

	logic          accept;
	logic [7:0]    node8;
	logic          node_ok;
	logic [NW-1:0] node_idx;
	logic [AW-1:0] base;
	logic          slot_ok;
	logic [AW-1:0] raddr;
	logic [63:0]   mask;
	logic [4:0]    len_now;
	logic          tbl_we;
	logic [AW-1:0] tbl_waddr;
	logic [7:0]    tbl_wdata;
	logic [6:0]    max_new;
	logic [4:0]    fill;
	lowbit_t       pick;

	palt_lowbit u_lowbit (
		.bits (bits_q),
		.pick (pick)
	);

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

	assign cap      = ({2'b00, row_cap_q} > MD7) ? MD7[4:0] : row_cap_q;
	assign node8    = {2'b00, cmd.node};
	assign node_ok  = node8 < NODES8;
	assign node_idx = node_ok ? NW'(node8) : '0;
	assign base     = AW'(node_idx) * STRIDE;
	assign slot_ok  = node_ok && ({1'b0, cmd.slot} < cap);
	assign raddr    = slot_ok ? base + AW'(cmd.slot) : base;
	assign mask     = (node_count_q >= 7'd64) ? '1 : ((64'd1 << node_count_q[5:0]) - 64'd1);
	assign len_now  = vld_rd_q ? len_rd_q : 5'd0;
	assign max_new  = (kind_q == KIND_LOAD && deg_q > max_q) ? deg_q : max_q;
	assign fill     = !node_ok_q ? 5'd0 : ((len_q < cap) ? len_q : cap);

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = base_q + AW'(len_now);
		tbl_wdata = {2'b00, neighbor_q};
		if (state_q == S_RD && kind_q == KIND_ADD && node_ok_q && len_now < cap) begin
			tbl_we = 1'b1;
		end else if (state_q == S_SCAN) begin
			tbl_waddr = base_q + AW'(len_q);
			tbl_wdata = {2'b00, pick.idx};
			tbl_we    = pick.found && node_ok_q && (len_q < cap);
		end
	end

	// memories: synchronous read, one write port each
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		if (accept) begin
			tbl_rd_q <= tbl_mem[raddr];
			len_rd_q <= len_mem[node_idx];
			vld_rd_q <= vld_q[node_idx];
		end
		if (state_q == S_WB && node_ok_q) begin
			len_mem[node_idx_q] <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			row_cap_q    <= ROW_CAPACITY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NODE_COUNT:   node_count_q <= cfg_data;
				REG_ROW_CAPACITY: row_cap_q    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// command fields and scan datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= cmd.kind;
			neighbor_q <= cmd.neighbor;
			slot_q     <= cmd.slot;
			node_ok_q  <= node_ok;
			slot_ok_q  <= slot_ok;
			node_idx_q <= node_idx;
			base_q     <= base;
			bits_q     <= cmd.row_bits & mask;
			deg_q      <= 7'd0;
			ovf_q      <= 1'b0;
			rv_q       <= EMPTY_SLOT;
		end
		case (state_q)
			S_RD: begin
				if (kind_q == KIND_ADD) begin
					if (node_ok_q && len_now < cap) begin
						len_q <= len_now + 5'd1;
					end else begin
						len_q <= len_now;
						ovf_q <= 1'b1;
					end
				end else begin
					len_q <= len_now;
				end
				if (kind_q == KIND_READ && slot_ok_q && {1'b0, slot_q} < len_now) begin
					rv_q <= tbl_rd_q;
				end
			end
			S_SCAN: begin
				if (pick.found) begin
					bits_q <= pick.rest;
					deg_q  <= deg_q + 7'd1;
					if (node_ok_q && len_q < cap) begin
						len_q <= len_q + 5'd1;
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.kind == KIND_CLEAR) begin
			res_q.read_value      <= EMPTY_SLOT;
			res_q.overflow        <= 1'b0;
			res_q.row_fill        <= 5'd0;
			res_q.max_degree_seen <= 7'd0;
		end else if (state_q == S_WB) begin
			res_q.read_value      <= rv_q;
			res_q.overflow        <= ovf_q;
			res_q.row_fill        <= fill;
			res_q.max_degree_seen <= max_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			vld_q   <= '0;
			max_q   <= 7'd0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.kind == KIND_CLEAR) begin
							vld_q  <= '0;
							max_q  <= 7'd0;
							done_q <= 1'b1;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= (kind_q == KIND_LOAD) ? S_SCAN : S_WB;
				end
				S_SCAN: begin
					if (!pick.found) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (node_ok_q) begin
						vld_q[node_idx_q] <= 1'b1;
					end
					max_q   <= max_new;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE)
		else $error("result strobe outside idle");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted command neither busy nor finished");

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.row_fill <= cap)
		else $error("row fill above capacity");

	a_read_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.read_value != EMPTY_SLOT) |-> kind_q == KIND_READ)
		else $error("slot value returned for a non-read command");

	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && tbl_we) |-> len_q < cap)
		else $error("row write past capacity during scan");

endmodule
